// ===== rtl/core/ats_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants of the aging task scheduler.
// -----------------------------------------------------------------------------
package ats_pkg;

   // table geometry
   localparam int NUM_TASKS   = 8;
   localparam int SLOT_W      = $clog2(NUM_TASKS);
   localparam int STACK_SHIFT = 10;

   // field widths
   localparam int OPCODE_W    = 3;
   localparam int TASK_ID_W   = 3;
   localparam int PTR_W       = 32;
   localparam int TICKS_W     = 32;
   localparam int SLOT_IDX_W  = 4;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // constants
   localparam logic [PTR_W-1:0]   STACK_GAP    = PTR_W'(64);
   localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(1000);
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

   // operation codes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK   = 3'd0,
      OP_ADD    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_DELAY  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STACK_TOP   = 1'd0,
      CSR_STAT_WINDOW = 1'd1
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic tick_start;
      logic walk_step;
      logic tick_finish;
      logic exec_op;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_tick;
      logic walk_last;
   } status_type;

endpackage

// ===== rtl/core/ats_channels.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ats channel interfaces
// Request, response and register write channels with valid/ready handshake.
// -----------------------------------------------------------------------------
interface ats_req_if;
   logic                            valid;
   logic                            ready;
   logic [ats_pkg::OPCODE_W-1:0]    opcode;
   logic [ats_pkg::TASK_ID_W-1:0]   task_id;
   logic [ats_pkg::PTR_W-1:0]       saved_pointer;
   logic [ats_pkg::TICKS_W-1:0]     ticks;

   modport source (output valid, opcode, task_id, saved_pointer, ticks, input ready);
   modport sink   (input valid, opcode, task_id, saved_pointer, ticks, output ready);
endinterface

interface ats_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ats_pkg::SLOT_IDX_W-1:0]  slot_index;
   logic [ats_pkg::PTR_W-1:0]       pointer_out;
   logic [ats_pkg::COUNT_W-1:0]     last_run_count;
   logic                            slot_live;

   modport source (output valid, slot_index, pointer_out, last_run_count, slot_live,
                   input ready);
   modport sink   (input valid, slot_index, pointer_out, last_run_count, slot_live,
                   output ready);
endinterface

interface ats_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ats_pkg::CSR_INDEX_W-1:0] index;
   logic [ats_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/aging_task_scheduler.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aging_task_scheduler
// Eight-slot task table with aging round-robin selection on each tick.
// -----------------------------------------------------------------------------
// Usage:
//   req_bus carries one operation per beat (tick, add, remove, delay, read);
//   every request beat produces exactly one response beat on rsp_bus.
//   csr_bus writes stack_top (index 0) and stat_window (index 1); it is always
//   ready and is meant to be written while no request is in flight.
// Sequence (one request at a time, taken again once its result is loaded):
//   add, remove, delay, read and unknown codes: capture, execute, then load
//   the result into the response register.
//   tick: capture, then the slot walk visits slots 0 to highest_slot one per
//   cycle, then the winner update and the load into the response register.
// Stalls:
//   the response sits in an output register; a new request is accepted while
//   it waits, and the block holds the next result until rsp_bus is free.
// Reset:
//   synchronous; empties the table, clears all counters, stack_top goes to 0
//   and stat_window to 1000.
// -----------------------------------------------------------------------------
module aging_task_scheduler (
   input logic        clock,
   input logic        reset,
   ats_req_if.sink    req_bus,
   ats_rsp_if.source  rsp_bus,
   ats_csr_if.sink    csr_bus
);

   ats_pkg::cmd_type    cmd;
   ats_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   // sequencer
   ats_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and datapath
   ats_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_bus.opcode),
      .req_task_id        (req_bus.task_id),
      .req_saved_pointer  (req_bus.saved_pointer),
      .req_ticks          (req_bus.ticks),
      .csr_write          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_slot_index     (rsp_bus.slot_index),
      .rsp_pointer_out    (rsp_bus.pointer_out),
      .rsp_last_run_count (rsp_bus.last_run_count),
      .rsp_slot_live      (rsp_bus.slot_live)
   );

endmodule

// ===== rtl/core/ats_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ats_ctrl
// Sequencer: takes a request beat, steps the datapath through the slot walk
// or the table operation and hands the result to the response register.
// -----------------------------------------------------------------------------
module ats_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ats_pkg::status_type status,
   output ats_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_FINISH,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            if (status.is_tick) begin
               cmd.tick_start = 1'b1;
               state_in       = ST_WALK;
            end else begin
               cmd.exec_op = 1'b1;
               state_in    = ST_OUT;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.tick_finish = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/ats_datapath.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ats_datapath
// Task table, registers, slot walk unit and response register of the
// scheduler, driven by commands from the sequencer.
// -----------------------------------------------------------------------------
module ats_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ats_pkg::cmd_type                    cmd,
   output ats_pkg::status_type                 status,
   // request beat
   input  logic [ats_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [ats_pkg::TASK_ID_W-1:0]       req_task_id,
   input  logic [ats_pkg::PTR_W-1:0]           req_saved_pointer,
   input  logic [ats_pkg::TICKS_W-1:0]         req_ticks,
   // register writes
   input  logic                                csr_write,
   input  logic [ats_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ats_pkg::CSR_DATA_W-1:0]      csr_data,
   // response beat
   output logic [ats_pkg::SLOT_IDX_W-1:0]      rsp_slot_index,
   output logic [ats_pkg::PTR_W-1:0]           rsp_pointer_out,
   output logic [ats_pkg::COUNT_W-1:0]         rsp_last_run_count,
   output logic                                rsp_slot_live
);

   localparam int SW = ats_pkg::SLOT_W;
   localparam int PW = ats_pkg::PTR_W;
   localparam int CW = ats_pkg::COUNT_W;

   // captured request
   logic [ats_pkg::OPCODE_W-1:0]  op_ff;
   logic [ats_pkg::TASK_ID_W-1:0] id_ff;
   logic [PW-1:0]                 saved_ff;
   logic [ats_pkg::TICKS_W-1:0]   ticks_ff;

   // registers
   logic [PW-1:0] stack_top_ff;
   logic [CW-1:0] stat_window_ff;

   // task table
   logic [PW-1:0]                 ptr_ff   [ats_pkg::NUM_TASKS];
   logic [ats_pkg::TICKS_W-1:0]   delay_ff [ats_pkg::NUM_TASKS];
   logic [CW-1:0]                 skip_ff  [ats_pkg::NUM_TASKS];
   logic [CW-1:0]                 run_ff   [ats_pkg::NUM_TASKS];
   logic [CW-1:0]                 last_ff  [ats_pkg::NUM_TASKS];

   // scheduler state
   logic [SW-1:0] active_ff;
   logic [SW-1:0] highest_ff;
   logic [CW-1:0] window_ff;
   logic          latch_ff;
   logic [SW-1:0] idx_ff;
   logic [CW-1:0] best_ff;
   logic [SW-1:0] win_ff;

   // result and response registers
   logic [ats_pkg::SLOT_IDX_W-1:0] res_slot_ff,  rsp_slot_ff;
   logic [PW-1:0]                  res_ptr_ff,   rsp_ptr_ff;
   logic [CW-1:0]                  res_last_ff,  rsp_last_ff;
   logic                           res_live_ff,  rsp_live_ff;

   // decode
   ats_pkg::op_type   op;
   logic              id_ok;
   logic [SW-1:0]     id_slot;
   logic [SW-1:0]     rd_addr;
   logic [PW-1:0]     rd_ptr;
   logic [ats_pkg::TICKS_W-1:0] rd_delay;
   logic [CW-1:0]     rd_skip;
   logic [CW-1:0]     rd_run;
   logic [CW-1:0]     rd_last;
   logic              rd_live;

   // free slot search and new pointer
   logic              free_found;
   logic [SW-1:0]     free_slot;
   logic [PW-1:0]     new_ptr;

   // window counter
   logic [CW:0]       window_next;
   logic              window_wrap;

   assign op      = ats_pkg::op_type'(op_ff);
   assign id_ok   = (32'(id_ff) < 32'(ats_pkg::NUM_TASKS));
   assign id_slot = id_ff[SW-1:0];

   // shared read port on the table, apart from the free slot search
   always_comb begin
      rd_addr = idx_ff;
      if (cmd.tick_start) begin
         rd_addr = active_ff;
      end else if (cmd.tick_finish) begin
         rd_addr = win_ff;
      end else if (cmd.exec_op) begin
         rd_addr = (op == ats_pkg::OP_READ) ? id_slot : active_ff;
      end
   end

   assign rd_ptr   = ptr_ff[rd_addr];
   assign rd_delay = delay_ff[rd_addr];
   assign rd_skip  = skip_ff[rd_addr];
   assign rd_run   = run_ff[rd_addr];
   assign rd_last  = last_ff[rd_addr];
   assign rd_live  = (rd_ptr != '0);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = ats_pkg::NUM_TASKS - 1; s >= 0; s--) begin
         if (ptr_ff[s] == '0) begin
            free_found = 1'b1;
            free_slot  = SW'(s);
         end
      end
   end

   assign new_ptr = stack_top_ff
                  - (PW'({1'b0, free_slot} + 1'b1) << ats_pkg::STACK_SHIFT)
                  - ats_pkg::STACK_GAP;

   // statistics window count, a window of zero latches on every tick
   assign window_next = {1'b0, window_ff} + 1'b1;
   assign window_wrap = (window_next >= {1'b0, stat_window_ff});

   assign status.is_tick   = (op == ats_pkg::OP_TICK);
   assign status.walk_last = (idx_ff == highest_ff);

   // captured request and walk scratch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         id_ff    <= req_task_id;
         saved_ff <= req_saved_pointer;
         ticks_ff <= req_ticks;
      end
      if (cmd.tick_start) begin
         idx_ff  <= '0;
         best_ff <= '0;
         win_ff  <= '0;
      end else if (cmd.walk_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (rd_live && rd_delay == '0 && rd_skip > best_ff) begin
            best_ff <= rd_skip;
            win_ff  <= idx_ff;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_top_ff   <= '0;
         stat_window_ff <= ats_pkg::WINDOW_RESET;
      end else if (csr_write) begin
         case (ats_pkg::csr_index_type'(csr_index))
            ats_pkg::CSR_STACK_TOP:   stack_top_ff   <= csr_data;
            ats_pkg::CSR_STAT_WINDOW: stat_window_ff <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // task table and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ats_pkg::NUM_TASKS; s++) begin
            ptr_ff[s]   <= '0;
            delay_ff[s] <= '0;
            skip_ff[s]  <= '0;
            run_ff[s]   <= '0;
            last_ff[s]  <= '0;
         end
         active_ff  <= '0;
         highest_ff <= '0;
         window_ff  <= '0;
         latch_ff   <= 1'b0;
      end else begin
         // tick: window count and save of the active pointer
         if (cmd.tick_start) begin
            window_ff <= window_wrap ? '0 : window_next[CW-1:0];
            latch_ff  <= window_wrap;
            if (rd_live) begin
               ptr_ff[active_ff] <= saved_ff;
            end
         end
         // tick: one live slot per cycle
         if (cmd.walk_step && rd_live) begin
            if (rd_delay != '0) begin
               delay_ff[idx_ff] <= rd_delay - 1'b1;
            end
            if (rd_skip != ats_pkg::COUNT_MAX) begin
               skip_ff[idx_ff] <= rd_skip + 1'b1;
            end
            if (latch_ff) begin
               last_ff[idx_ff] <= rd_run;
               run_ff[idx_ff]  <= '0;
            end
         end
         // tick: winner update
         if (cmd.tick_finish) begin
            skip_ff[win_ff] <= '0;
            run_ff[win_ff]  <= rd_run + 1'b1;
            active_ff       <= win_ff;
         end
         // table operations
         if (cmd.exec_op) begin
            case (op)
               ats_pkg::OP_ADD: begin
                  if (free_found) begin
                     ptr_ff[free_slot]   <= new_ptr;
                     delay_ff[free_slot] <= ticks_ff;
                     skip_ff[free_slot]  <= '0;
                     if (free_slot > highest_ff) begin
                        highest_ff <= free_slot;
                     end
                  end
               end
               ats_pkg::OP_REMOVE: begin
                  if (id_ok) begin
                     ptr_ff[id_slot] <= '0;
                  end
               end
               ats_pkg::OP_DELAY: begin
                  delay_ff[active_ff] <= ticks_ff;
               end
               default: ;
            endcase
         end
      end
   end

   // result of the finished operation
   always_ff @(posedge clock) begin
      if (cmd.tick_finish) begin
         res_slot_ff <= ats_pkg::SLOT_IDX_W'(win_ff);
         res_ptr_ff  <= rd_ptr;
         res_last_ff <= '0;
         res_live_ff <= rd_live;
      end else if (cmd.exec_op) begin
         res_slot_ff <= '0;
         res_ptr_ff  <= '0;
         res_last_ff <= '0;
         res_live_ff <= 1'b0;
         case (op)
            ats_pkg::OP_ADD: begin
               if (free_found) begin
                  res_slot_ff <= ats_pkg::SLOT_IDX_W'(free_slot);
                  res_ptr_ff  <= new_ptr;
                  res_live_ff <= (new_ptr != '0);
               end else begin
                  res_slot_ff <= ats_pkg::SLOT_IDX_W'(ats_pkg::NUM_TASKS);
               end
            end
            ats_pkg::OP_REMOVE: begin
               res_slot_ff <= ats_pkg::SLOT_IDX_W'(id_ff);
            end
            ats_pkg::OP_DELAY: begin
               res_slot_ff <= ats_pkg::SLOT_IDX_W'(active_ff);
            end
            ats_pkg::OP_READ: begin
               res_slot_ff <= ats_pkg::SLOT_IDX_W'(id_ff);
               if (id_ok) begin
                  res_ptr_ff  <= rd_ptr;
                  res_last_ff <= rd_last;
                  res_live_ff <= rd_live;
               end
            end
            default: ;
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_slot_ff <= res_slot_ff;
         rsp_ptr_ff  <= res_ptr_ff;
         rsp_last_ff <= res_last_ff;
         rsp_live_ff <= res_live_ff;
      end
   end

   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_pointer_out    = rsp_ptr_ff;
   assign rsp_last_run_count = rsp_last_ff;
   assign rsp_slot_live      = rsp_live_ff;

endmodule

// ===== sim/tb_aging_task_scheduler.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_aging_task_scheduler
// Self-checking bench for the aging task scheduler. A short table of directed
// beats covers empty-table ticks, a full table, pointers that come out as zero,
// freeing the active task on a tick and the spare opcodes. Several phases of
// random beats follow, each phase under its own stack top and statistics
// window. Every response is checked field by field, against a typed-in answer
// or a behavioural copy of the task table kept inside the bench. Both
// channels idle at random.
module tb_aging_task_scheduler;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 90;

   // opcodes the block does not decode
   localparam logic [ats_pkg::OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [ats_pkg::OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [ats_pkg::OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [ats_pkg::OPCODE_W-1:0]  opcode;
      logic [ats_pkg::TASK_ID_W-1:0] task_id;
      logic [ats_pkg::PTR_W-1:0]     saved_pointer;
      logic [ats_pkg::TICKS_W-1:0]   ticks;
   } sched_req_type;

   typedef struct packed {
      logic [ats_pkg::SLOT_IDX_W-1:0] slot_index;
      logic [ats_pkg::PTR_W-1:0]      pointer_out;
      logic [ats_pkg::COUNT_W-1:0]    last_run_count;
      logic                           slot_live;
   } sched_rsp_type;

   // directed rows: checked against the table copy, typed-in answer, or a
   // register write (stack top in saved_pointer, window in ticks)
   typedef enum logic [1:0] {ROW_CHECKED, ROW_TYPED, ROW_REGS} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      sched_req_type req;
      sched_rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   ats_req_if req_bus ();
   ats_rsp_if rsp_bus ();
   ats_csr_if csr_bus ();

   aging_task_scheduler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // behavioural copy of the task table
   logic [ats_pkg::PTR_W-1:0]   task_ptr       [ats_pkg::NUM_TASKS] = '{default: '0};
   logic [ats_pkg::TICKS_W-1:0] task_delay     [ats_pkg::NUM_TASKS] = '{default: '0};
   logic [ats_pkg::COUNT_W-1:0] task_skip      [ats_pkg::NUM_TASKS] = '{default: '0};
   logic [ats_pkg::COUNT_W-1:0] task_runs      [ats_pkg::NUM_TASKS] = '{default: '0};
   logic [ats_pkg::COUNT_W-1:0] task_runs_last [ats_pkg::NUM_TASKS] = '{default: '0};
   logic [ats_pkg::SLOT_W-1:0]  cur_slot  = '0;
   logic [ats_pkg::SLOT_W-1:0]  top_slot  = '0;
   logic [ats_pkg::COUNT_W-1:0] win_count = '0;
   logic [ats_pkg::PTR_W-1:0]   cfg_stack_top = '0;
   logic [ats_pkg::COUNT_W-1:0] cfg_window    = ats_pkg::WINDOW_RESET;

   sched_rsp_type answers_due [$];
   stim_row_type  stim_rows [$];

   int  fail_count   = 0;
   int  beats_sent   = 0;
   int  ticks_sent   = 0;
   int  answers_seen = 0;
   int  reg_writes   = 0;
   int  cycle_count  = 0;
   bit  req_calm     = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_aging_task_scheduler NOT OK");
      $finish;
   end

   // answer of the task table to one beat, updating the copy
   function automatic sched_rsp_type scheduler_answer(input sched_req_type rq);
      sched_rsp_type             ans;
      int                        next_count;
      int                        winner;
      int                        best;
      bit                        latch;
      logic [ats_pkg::PTR_W-1:0] fresh;
      int                        s;
      ans = '0;
      case (rq.opcode)
         ats_pkg::OP_TICK: begin
            // window count, then save the outgoing task's pointer
            next_count = int'(win_count) + 1;
            latch = 1'b0;
            if (next_count >= int'(cfg_window)) begin
               next_count = 0;
               latch = 1'b1;
            end
            win_count = ats_pkg::COUNT_W'(next_count);
            if (task_ptr[cur_slot] != '0)
               task_ptr[cur_slot] = rq.saved_pointer;
            // walk live slots: count delays down, oldest ready slot wins
            winner = 0;
            best = 0;
            for (s = 0; s <= int'(top_slot); s++) begin
               if (task_ptr[s] != '0) begin
                  if (task_delay[s] != '0)
                     task_delay[s] = task_delay[s] - 1'b1;
                  else if (int'(task_skip[s]) > best) begin
                     best = int'(task_skip[s]);
                     winner = s;
                  end
                  if (task_skip[s] != ats_pkg::COUNT_MAX)
                     task_skip[s] = task_skip[s] + 1'b1;
                  if (latch) begin
                     task_runs_last[s] = task_runs[s];
                     task_runs[s] = '0;
                  end
               end
            end
            task_skip[winner] = '0;
            task_runs[winner] = task_runs[winner] + 1'b1;
            cur_slot = ats_pkg::SLOT_W'(winner);
            ans.slot_index = ats_pkg::SLOT_IDX_W'(winner);
            ans.pointer_out = task_ptr[winner];
            ans.slot_live = (task_ptr[winner] != '0);
         end
         ats_pkg::OP_ADD: begin
            winner = ats_pkg::NUM_TASKS;
            for (s = ats_pkg::NUM_TASKS - 1; s >= 0; s--)
               if (task_ptr[s] == '0)
                  winner = s;
            ans.slot_index = ats_pkg::SLOT_IDX_W'(winner);
            if (winner < ats_pkg::NUM_TASKS) begin
               fresh = cfg_stack_top
                     - (ats_pkg::PTR_W'(winner + 1) << ats_pkg::STACK_SHIFT)
                     - ats_pkg::STACK_GAP;
               task_ptr[winner] = fresh;
               task_delay[winner] = rq.ticks;
               task_skip[winner] = '0;
               if (winner > int'(top_slot))
                  top_slot = ats_pkg::SLOT_W'(winner);
               ans.pointer_out = fresh;
               ans.slot_live = (fresh != '0);
            end
         end
         ats_pkg::OP_REMOVE: begin
            task_ptr[rq.task_id] = '0;
            ans.slot_index = ats_pkg::SLOT_IDX_W'(rq.task_id);
         end
         ats_pkg::OP_DELAY: begin
            task_delay[cur_slot] = rq.ticks;
            ans.slot_index = ats_pkg::SLOT_IDX_W'(cur_slot);
         end
         ats_pkg::OP_READ: begin
            ans.slot_index = ats_pkg::SLOT_IDX_W'(rq.task_id);
            ans.pointer_out = task_ptr[rq.task_id];
            ans.last_run_count = task_runs_last[rq.task_id];
            ans.slot_live = (task_ptr[rq.task_id] != '0);
         end
         default: ans = '0;
      endcase
      return ans;
   endfunction

   function automatic void put_row(input row_kind_type kind,
                                   input logic [ats_pkg::OPCODE_W-1:0] op,
                                   input logic [ats_pkg::TASK_ID_W-1:0] id,
                                   input logic [ats_pkg::PTR_W-1:0] sp,
                                   input logic [ats_pkg::TICKS_W-1:0] tk,
                                   input sched_rsp_type rsp);
      stim_row_type r;
      r.kind = kind;
      r.req = {op, id, sp, tk};
      r.rsp = rsp;
      stim_rows.push_back(r);
   endfunction

   // random beat, mostly ticks and table maintenance
   function automatic sched_req_type random_beat();
      sched_req_type rq;
      int            pick;
      pick = $urandom_range(0, 99);
      rq.task_id = ats_pkg::TASK_ID_W'($urandom_range(0, ats_pkg::NUM_TASKS - 1));
      rq.saved_pointer = ($urandom_range(0, 19) == 0) ? '0 : ats_pkg::PTR_W'($urandom);
      rq.ticks = ($urandom_range(0, 9) == 0) ? ats_pkg::TICKS_W'($urandom)
                                             : ats_pkg::TICKS_W'($urandom_range(0, 4));
      if (pick < 45)
         rq.opcode = ats_pkg::OP_TICK;
      else if (pick < 62)
         rq.opcode = ats_pkg::OP_ADD;
      else if (pick < 74)
         rq.opcode = ats_pkg::OP_REMOVE;
      else if (pick < 84)
         rq.opcode = ats_pkg::OP_DELAY;
      else if (pick < 97)
         rq.opcode = ats_pkg::OP_READ;
      else
         rq.opcode = OP_SPARE_LO + ats_pkg::OPCODE_W'($urandom_range(0, 2));
      return rq;
   endfunction

   // one request beat, with a random gap ahead of it
   task automatic send_beat(input sched_req_type rq, input bit typed,
                            input sched_rsp_type typed_rsp);
      int            gap;
      sched_rsp_type ans;
      if (beats_sent % 32 == 0)
         req_calm = ($urandom_range(0, 3) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= rq.opcode;
      req_bus.task_id       <= rq.task_id;
      req_bus.saved_pointer <= rq.saved_pointer;
      req_bus.ticks         <= rq.ticks;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      ans = scheduler_answer(rq);
      answers_due.push_back(typed ? typed_rsp : ans);
      beats_sent++;
      if (rq.opcode == ats_pkg::OP_TICK)
         ticks_sent++;
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // write both registers back to back while the block is idle
   task automatic set_config(input logic [ats_pkg::PTR_W-1:0] top,
                             input logic [ats_pkg::COUNT_W-1:0] window);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= ats_pkg::CSR_STACK_TOP;
      csr_bus.data  <= ats_pkg::CSR_DATA_W'(top);
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      cfg_stack_top = top;
      csr_bus.index <= ats_pkg::CSR_STAT_WINDOW;
      csr_bus.data  <= ats_pkg::CSR_DATA_W'(window);
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      cfg_window = window;
      csr_bus.valid <= 1'b0;
      reg_writes += 2;
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
      fail_count++;
   endtask

   // response side: random back-pressure and field checks
   initial begin
      sched_rsp_type got;
      sched_rsp_type want;
      int            hold;
      bit            calm;
      hold = 0;
      calm = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = {rsp_bus.slot_index, rsp_bus.pointer_out, rsp_bus.last_run_count,
                   rsp_bus.slot_live};
            if (answers_due.size() == 0) begin
               $display("%0t ns: response beat with nothing outstanding, actual %h",
                        $time, got);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (got.slot_index !== want.slot_index)
                  report_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
               if (got.pointer_out !== want.pointer_out)
                  report_field("pointer_out", want.pointer_out, got.pointer_out);
               if (got.last_run_count !== want.last_run_count)
                  report_field("last_run_count", 32'(want.last_run_count),
                               32'(got.last_run_count));
               if (got.slot_live !== want.slot_live)
                  report_field("slot_live", 32'(want.slot_live), 32'(got.slot_live));
            end
            answers_seen++;
            if (answers_seen % 32 == 0)
               calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 13);
            rsp_bus.ready <= (hold == 0);
         end else if (hold != 0) begin
            hold--;
            rsp_bus.ready <= (hold == 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      int            phase;
      int            n;
      sched_req_type rq;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = ats_pkg::OP_TICK;
      req_bus.task_id = '0;
      req_bus.saved_pointer = '0;
      req_bus.ticks = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = ats_pkg::CSR_STACK_TOP;
      csr_bus.data = '0;

      // empty table straight after reset, spare opcodes
      put_row(ROW_TYPED, ats_pkg::OP_READ, 3'd7, '0, '0, {4'd7, 32'd0, 16'd0, 1'b0});
      put_row(ROW_TYPED, ats_pkg::OP_TICK, 3'd0, 32'hFFFF_FFFF, '0,
              {4'd0, 32'd0, 16'd0, 1'b0});
      put_row(ROW_TYPED, OP_SPARE_HI, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      put_row(ROW_TYPED, OP_SPARE_LO, 3'd5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, '0);
      // first add with a stack top of zero wraps round
      put_row(ROW_TYPED, ats_pkg::OP_ADD, 3'd0, '0, '0, {4'd0, 32'hFFFF_FBC0, 16'd0, 1'b1});
      // top of memory, window of one: every tick closes a window
      put_row(ROW_REGS, ats_pkg::OP_TICK, '0, 32'hFFFF_FFFF, 32'd1, '0);
      put_row(ROW_TYPED, ats_pkg::OP_ADD, 3'd0, '0, 32'hFFFF_FFFF,
              {4'd1, 32'hFFFF_F7BF, 16'd0, 1'b1});
      put_row(ROW_CHECKED, ats_pkg::OP_ADD, 3'd0, '0, 32'd0, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_ADD, 3'd0, '0, 32'd1, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_ADD, 3'd0, '0, 32'd2, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_ADD, 3'd0, '0, 32'd0, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_ADD, 3'd0, '0, 32'd5, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_ADD, 3'd0, '0, 32'd0, '0);
      // table full
      put_row(ROW_TYPED, ats_pkg::OP_ADD, 3'd0, '0, 32'd7,
              {ats_pkg::SLOT_IDX_W'(ats_pkg::NUM_TASKS), 32'd0, 16'd0, 1'b0});
      // zero saved pointer frees the task that was running
      put_row(ROW_CHECKED, ats_pkg::OP_TICK, 3'd0, 32'd0, '0, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_DELAY, 3'd0, '0, 32'd3, '0);
      // removing the top slot leaves the walk length alone
      put_row(ROW_TYPED, ats_pkg::OP_REMOVE, 3'd7, '0, '0, {4'd7, 32'd0, 16'd0, 1'b0});
      put_row(ROW_CHECKED, ats_pkg::OP_TICK, 3'd0, 32'h1234_5678, '0, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_READ, 3'd0, '0, '0, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_READ, 3'd1, '0, '0, '0);
      // stack top that gives slot 0 a zero pointer, window of zero
      put_row(ROW_REGS, ats_pkg::OP_TICK, '0, 32'h0000_0440, 32'd0, '0);
      put_row(ROW_TYPED, ats_pkg::OP_ADD, 3'd0, '0, 32'd0, {4'd0, 32'd0, 16'd0, 1'b0});
      put_row(ROW_TYPED, ats_pkg::OP_ADD, 3'd0, '0, 32'd0, {4'd0, 32'd0, 16'd0, 1'b0});
      put_row(ROW_CHECKED, ats_pkg::OP_TICK, 3'd0, 32'hAAAA_AAAA, '0, '0);
      put_row(ROW_CHECKED, ats_pkg::OP_READ, 3'd3, '0, '0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_REGS) begin
            settle();
            set_config(stim_rows[i].req.saved_pointer,
                       stim_rows[i].req.ticks[ats_pkg::COUNT_W-1:0]);
         end else begin
            send_beat(stim_rows[i].req, stim_rows[i].kind == ROW_TYPED, stim_rows[i].rsp);
         end
      end

      // random phases, each under its own register setting
      for (phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: set_config(ats_pkg::PTR_W'($urandom), 16'd3);
            1: set_config('0, 16'd2);
            2: set_config('1, ats_pkg::COUNT_MAX);
            3: set_config(ats_pkg::PTR_W'($urandom),
                          ats_pkg::COUNT_W'($urandom_range(1, 12)));
            default: set_config(ats_pkg::PTR_W'($urandom), 16'd1);
         endcase
         for (n = 0; n < PHASE_BEATS; n++) begin
            rq = random_beat();
            send_beat(rq, 1'b0, '0);
         end
      end

      settle();
      repeat (16) @(posedge clock);
      $display("covered %0d request beats (%0d ticks) and %0d responses checked",
               beats_sent, ticks_sent, answers_seen);
      $display("register writes: %0d, over seven stack top and window settings", reg_writes);
      if (fail_count == 0 && answers_due.size() == 0)
         $display("tb_aging_task_scheduler OK");
      else
         $display("tb_aging_task_scheduler NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ats_pkg.sv
rtl/core/ats_channels.sv
rtl/core/ats_ctrl.sv
rtl/core/ats_datapath.sv
rtl/core/aging_task_scheduler.sv
sim/tb_aging_task_scheduler.sv
